[hw/rtl/bthc_pkg.sv]
`timescale 1ns / 1ps

package bthc_pkg;

	// Field widths
	localparam int unsigned DATA_W    = 8;
	localparam int unsigned THR_W     = 7;
	localparam int unsigned IDX_W     = 8;
	localparam int unsigned FUNC_W    = 2;
	localparam int unsigned WIN_SUM_W = 16;
	localparam int unsigned HIST_W    = 10;

	// Operation codes carried by func
	typedef enum logic [FUNC_W-1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_REARM  = 2'd2
	} func_t;

	// Window counter thresholds
	localparam logic [7:0] HIST_START   = 8'd4;
	localparam logic [7:0] OFFSET_START = 8'd12;

	// Reset values
	localparam logic [THR_W-1:0]         THR_RESET      = 7'd16;
	localparam logic signed [DATA_W-1:0] LIMIT_HI_RESET = 8'sh7F;
	localparam logic signed [DATA_W-1:0] LIMIT_LO_RESET = -8'sh7F;

endpackage

[hw/rtl/baseline_tracking_hit_capture_core.sv]
`timescale 1ns / 1ps

// Transient recorder with pretrigger and a self-calibrating baseline.
//
// Input channel (in_valid / in_stall) carries one transaction per cycle:
// a sample to record, a read of a stored entry (index 0 is the oldest), or
// a rearm. Every transaction yields exactly one result on the output
// channel (out_valid / out_stall) with read_data and the current status.
//
// A result appears the cycle after its transaction is accepted.
// Throughput is one transaction per cycle; the sample store is a single
// RAM with one write and one registered read port, and each transaction
// uses at most one of them. The output register only blocks new input
// while the receiver stalls a waiting result (in_stall follows out_stall
// whenever a result is pending).
//
// Reset clears all status, sets the limits to +/-127 and the threshold to
// 16. The store needs no clearing pass: a fill level tracks which entries
// were written, and an unwritten entry reads as zero.
// The configuration channel (cfg_valid / cfg_ready / cfg_data) writes the
// hit threshold; it is always ready and should be used while idle.

module baseline_tracking_hit_capture_core #(
	parameter int unsigned STORE_DEPTH = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bthc_pkg::THR_W-1:0]          cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [bthc_pkg::FUNC_W-1:0]         func,
	input  logic signed [bthc_pkg::DATA_W-1:0]  sample,
	input  logic [bthc_pkg::IDX_W-1:0]          read_index,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [bthc_pkg::DATA_W-1:0]  read_data,
	output logic                                hit_seen,
	output logic                                capture_done,
	output logic signed [bthc_pkg::DATA_W-1:0]  baseline,
	output logic signed [bthc_pkg::DATA_W-1:0]  upper_limit,
	output logic signed [bthc_pkg::DATA_W-1:0]  lower_limit
);

	import bthc_pkg::*;

	localparam int unsigned AW       = $clog2(STORE_DEPTH);
	localparam int unsigned STOP_OFF = STORE_DEPTH - STORE_DEPTH / 4;
	localparam int unsigned IDX_N    = 2 ** IDX_W;

	localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(STORE_DEPTH);
	localparam logic [AW:0]   STOP_X    = (AW + 1)'(STOP_OFF);
	localparam logic [AW-1:0] WP_LAST   = AW'(STORE_DEPTH - 1);

	// Read index folded into the store depth, built at elaboration
	typedef logic [AW-1:0] wrap_tab_t [IDX_N];

	function automatic wrap_tab_t build_wrap();
		wrap_tab_t   t;
		int unsigned r;
		r = 0;
		for (int unsigned i = 0; i < IDX_N; i++) begin
			t[i] = AW'(r);
			r = (r + 1 == STORE_DEPTH) ? 0 : r + 1;
		end
		return t;
	endfunction

	localparam wrap_tab_t RI_WRAP = build_wrap();

	// State registers
	logic [THR_W-1:0]          thr_q;
	logic [AW-1:0]             wp_q;
	logic                      filled_q;
	logic [AW-1:0]             stop_q;
	logic signed [WIN_SUM_W-1:0] win_sum_q;
	logic [7:0]                siw_q;
	logic [7:0]                wn_q;
	logic signed [DATA_W-1:0]  last_mean_q;
	logic signed [DATA_W-1:0]  hist_q [3];
	logic signed [DATA_W-1:0]  off_q;
	logic signed [DATA_W-1:0]  hi_q;
	logic signed [DATA_W-1:0]  lo_q;
	logic                      hit_q;
	logic                      done_q;
	logic                      out_valid_q;
	logic                      rd_ok_s1;

	// Handshake and decode
	logic  in_acc;
	func_t fn;
	logic  do_sample;
	logic  do_read;
	logic  do_rearm;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign in_acc    = in_valid & ~in_stall;
	assign fn        = func_t'(func);

	always_comb begin
		do_sample = 1'b0;
		do_read   = 1'b0;
		do_rearm  = 1'b0;
		unique case (fn)
			FUNC_SAMPLE: do_sample = in_acc & ~done_q;
			FUNC_READ:   do_read   = in_acc;
			FUNC_REARM:  do_rearm  = in_acc;
			default:     ;
		endcase
	end

	// Window accumulation
	logic signed [WIN_SUM_W-1:0] sum_next;
	logic [7:0]                  siw_next;
	logic [7:0]                  wn_next;
	logic                        win_end;
	logic signed [DATA_W-1:0]    mean_new;

	assign sum_next = win_sum_q + WIN_SUM_W'(sample);
	assign siw_next = siw_q + 8'd1;
	assign wn_next  = wn_q + 8'd1;
	assign win_end  = (siw_next == 8'd0);
	assign mean_new = sum_next[WIN_SUM_W-1 -: DATA_W];

	// Baseline: mean of history and last window, truncated toward zero
	logic signed [HIST_W-1:0] hist_sum;
	logic signed [HIST_W-1:0] hist_quot;
	logic signed [DATA_W-1:0] nb;
	logic                     hist_upd;
	logic                     off_upd;
	logic [DATA_W-1:0]        hi_calc;
	logic [DATA_W-1:0]        lo_calc;
	logic signed [DATA_W-1:0] hi_new;
	logic signed [DATA_W-1:0] lo_new;

	assign hist_sum  = HIST_W'(hist_q[0]) + HIST_W'(hist_q[1]) + HIST_W'(hist_q[2])
	                 + HIST_W'(last_mean_q);
	assign hist_quot = (hist_sum < 0) ? ((hist_sum + HIST_W'(3)) >>> 2) : (hist_sum >>> 2);
	assign nb        = hist_quot[DATA_W-1:0];
	assign hist_upd  = do_sample & win_end & (wn_next > HIST_START) & ~hit_q;
	assign off_upd   = hist_upd & (wn_next > OFFSET_START);
	assign hi_calc   = DATA_W'(nb) + DATA_W'(thr_q);
	assign lo_calc   = DATA_W'(nb) - DATA_W'(thr_q);
	assign hi_new    = off_upd ? signed'(hi_calc) : hi_q;
	assign lo_new    = off_upd ? signed'(lo_calc) : lo_q;

	// Write pointer, hit detection and stop position
	logic [AW-1:0] wp_next;
	logic          out_of_range;
	logic [AW:0]   stop_sum;
	logic [AW-1:0] stop_calc;

	assign wp_next      = (wp_q == WP_LAST) ? '0 : wp_q + AW'(1);
	assign out_of_range = (sample > hi_new) || (sample < lo_new);
	assign stop_sum     = {1'b0, wp_next} + STOP_X;
	always_comb begin
		if (stop_sum >= DEPTH_X) begin
			stop_calc = AW'(stop_sum - DEPTH_X);
		end else begin
			stop_calc = stop_sum[AW-1:0];
		end
	end

	// Read address, oldest entry first
	logic [AW:0]   rsum;
	logic [AW-1:0] raddr;
	logic          entry_ok;

	assign rsum = {1'b0, wp_q} + (AW + 1)'(1) + {1'b0, RI_WRAP[read_index]};
	always_comb begin
		if (rsum >= DEPTH_X) begin
			raddr = AW'(rsum - DEPTH_X);
		end else begin
			raddr = rsum[AW-1:0];
		end
	end
	assign entry_ok = filled_q | ((raddr != '0) & (raddr <= wp_q));

	// Sample store
	logic [DATA_W-1:0] mem_rdata;

	bthc_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (do_sample),
		.waddr (wp_next),
		.wdata (sample),
		.re    (do_read),
		.raddr (raddr),
		.rdata (mem_rdata)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	// Output register: valid flag and read mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rd_ok_s1    <= 1'b0;
		end else begin
			if (in_acc) begin
				out_valid_q <= 1'b1;
				rd_ok_s1    <= do_read & entry_ok;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Store pointer and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			filled_q <= 1'b0;
		end else if (do_sample) begin
			wp_q <= wp_next;
			if (wp_next == '0) begin
				filled_q <= 1'b1;
			end
		end
	end

	// Window, baseline and capture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q      <= '0;
			win_sum_q   <= '0;
			siw_q       <= '0;
			wn_q        <= '0;
			last_mean_q <= '0;
			hist_q[0]   <= '0;
			hist_q[1]   <= '0;
			hist_q[2]   <= '0;
			off_q       <= '0;
			hi_q        <= LIMIT_HI_RESET;
			lo_q        <= LIMIT_LO_RESET;
			hit_q       <= 1'b0;
			done_q      <= 1'b0;
		end else if (do_rearm) begin
			hit_q       <= 1'b0;
			done_q      <= 1'b0;
			stop_q      <= '0;
			win_sum_q   <= '0;
			siw_q       <= '0;
			wn_q        <= '0;
			last_mean_q <= '0;
		end else if (do_sample) begin
			siw_q <= siw_next;
			if (win_end) begin
				wn_q        <= wn_next;
				last_mean_q <= mean_new;
				win_sum_q   <= '0;
			end else begin
				win_sum_q <= sum_next;
			end
			if (hist_upd) begin
				hist_q[0] <= hist_q[1];
				hist_q[1] <= hist_q[2];
				hist_q[2] <= last_mean_q;
			end
			if (off_upd) begin
				off_q <= nb;
				hi_q  <= hi_new;
				lo_q  <= lo_new;
			end
			if (hit_q) begin
				if (stop_q == wp_next) begin
					done_q <= 1'b1;
				end
			end else if (out_of_range) begin
				hit_q  <= 1'b1;
				stop_q <= stop_calc;
			end
		end
	end

	// Drive result ports
	assign out_valid    = out_valid_q;
	assign read_data    = rd_ok_s1 ? signed'(mem_rdata) : '0;
	assign hit_seen     = hit_q;
	assign capture_done = done_q;
	assign baseline     = off_q;
	assign upper_limit  = hi_q;
	assign lower_limit  = lo_q;

endmodule

[hw/rtl/bthc_ram.sv]
`timescale 1ns / 1ps

module bthc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/bthc_checker.sv]
`timescale 1ns / 1ps

module bthc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [bthc_pkg::DATA_W-1:0]  read_data,
	input logic                                hit_seen,
	input logic                                capture_done,
	input logic signed [bthc_pkg::DATA_W-1:0]  baseline,
	input logic signed [bthc_pkg::DATA_W-1:0]  upper_limit,
	input logic signed [bthc_pkg::DATA_W-1:0]  lower_limit
);

	import bthc_pkg::*;

	logic [DATA_W-1:0] lim_sum;
	logic [DATA_W-1:0] base_x2;

	assign lim_sum = DATA_W'(upper_limit) + DATA_W'(lower_limit);
	assign base_x2 = DATA_W'(baseline) + DATA_W'(baseline);

	// Every accepted transaction yields a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("no result after accepted transaction");

	// Capture can only finish after a hit
	a_done_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && capture_done |-> hit_seen)
		else $error("capture done without hit");

	// Limits stay centered on the baseline
	a_limits_centered: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lim_sum == base_x2)
		else $error("limits not centered on baseline");

	// Hold a stalled result
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(hit_seen)
			&& $stable(capture_done) && $stable(baseline))
		else $error("stalled result changed");

endmodule

bind baseline_tracking_hit_capture_core bthc_checker u_bthc_checker (.*);
